>>> hw/rtl/fpic_pkg.sv
// Shared types and constants for the 3x3 fixed-point inverse/compose core.
package fpic_pkg;
	localparam logic [1:0] CMD_LOAD_LOCAL = 2'd0;
	localparam logic [1:0] CMD_LOAD_TARGET = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;
	localparam logic CFG_SCALE_MIN = 1'b0;
	localparam logic CFG_SCALE_MAX = 1'b1;
	localparam int CfgWidth = 25;
	localparam logic [CfgWidth-1:0] SCALE_MIN_RST = 25'd2048;
	localparam logic [CfgWidth-1:0] SCALE_MAX_RST = 25'd4096;
	localparam logic signed [15:0] ONE_Q12 = 16'sd4096;
	typedef struct packed {
		logic start;
		logic signed [47:0] num;
		logic signed [16:0] den;
	} div_req_t;
	typedef struct packed {
		logic done;
		logic signed [47:0] quo;
	} div_rsp_t;
endpackage

>>> hw/rtl/fpic_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module fpic_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fpic_pkg::div_req_t req,
	output fpic_pkg::div_rsp_t rsp
);
	import fpic_pkg::*;
	logic [47:0] rem_q, quo_q;
	logic [16:0] den_q;
	logic neg_q, busy_q, done_q;
	logic [5:0] cnt_q;
	logic [48:0] trial;
	logic [47:0] shifted;
	logic signed [47:0] quo_res;

	assign shifted = {rem_q[46:0], quo_q[47]};
	assign trial = {1'b0, shifted} - {32'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num[47] ? 48'(-req.num) : req.num;
			den_q <= req.den[16] ? 17'(-req.den) : req.den;
			neg_q <= req.num[47] ^ req.den[16];
		end else if (busy_q) begin
			if (!trial[48]) begin
				rem_q <= trial[47:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quo_res = neg_q ? 48'(-$signed(quo_q)) : $signed(quo_q);
	assign rsp = '{done: done_q, quo: quo_res};

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done longer than one cycle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider not busy after start");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !busy_q) else $error("done while busy");
endmodule

>>> hw/rtl/fixed_point_3x3_inverse_compose_core.sv
// Top level: matrix stores, sequencer, shared multiplier and divider.
// Load commands are taken one per cycle while idle. A run holds busy while the solver walks
// every pivot through one 16x32 multiplier and one 48-bit bit-serial divider: per pivot
// 2*ORDER divisions by the pivot, plus the pivot product and the elimination terms (division
// by 4096 is a shift). If the product of the pivots lies within the configured limits it
// then composes with the same multiplier; else the target is emitted unchanged. It emits
// ORDER*ORDER results, one per cycle, with strobe out_valid, each registered in S_EMIT.
// The receiver cannot stall; results must be taken as they appear.
module fixed_point_3x3_inverse_compose_core #(
	parameter int ORDER = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [1:0]  row,
	input  logic [1:0]  col,
	input  logic signed [15:0] value,
	output logic        out_valid,
	output logic [1:0]  out_row,
	output logic [1:0]  out_col,
	output logic signed [15:0] out_value,
	output logic        applied,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [fpic_pkg::CfgWidth-1:0] cfg_data
);
	import fpic_pkg::*;
	localparam int N = ORDER * ORDER;
	localparam logic [3:0] S_IDLE = 4'd0, S_PIV = 4'd1, S_PMUL = 4'd2, S_PDIV = 4'd3,
		S_NORM = 4'd4, S_NDIV = 4'd5, S_RECIP = 4'd6, S_RDIV = 4'd7,
		S_ELIM = 4'd8, S_EMUL = 4'd9, S_EDIV = 4'd10, S_CHK = 4'd11,
		S_COMP = 4'd12, S_EMIT = 4'd13;

	logic signed [15:0] loc_q [N];
	logic signed [15:0] tgt_q [N];
	logic signed [15:0] prod_q [N];
	logic [CfgWidth-1:0] smin_q, smax_q;
	logic [3:0] st_q;
	logic [1:0] i_q, j_q, k_q, r_q, c_q;
	logic signed [16:0] piv_q;
	logic signed [15:0] u_q;
	logic signed [31:0] scale_q;
	logic signed [47:0] mul_q, acc_q;
	logic ok_q, wait_q;
	div_req_t dreq;
	div_rsp_t drsp;

	fpic_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	function automatic logic [3:0] idx(input logic [1:0] a, input logic [1:0] b);
		return 4'(int'(a) * ORDER + int'(b));
	endfunction

	assign busy = (st_q != S_IDLE);
	assign cfg_ready = 1'b1;

	logic signed [15:0] mul_a;
	logic signed [31:0] mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_PMUL: begin mul_a = piv_q[15:0]; mul_b = scale_q; end
			S_EMUL: begin mul_a = loc_q[idx(i_q, k_q)]; mul_b = 32'(u_q); end
			S_COMP: begin mul_a = loc_q[idx(r_q, k_q)]; mul_b = 32'(tgt_q[idx(k_q, c_q)]); end
			default: ;
		endcase
	end

	logic [1:0] lastix;
	assign lastix = 2'(ORDER - 1);
	logic signed [47:0] cmp_sum, sh, term;
	assign cmp_sum = acc_q + mul_q;
	assign sh = cmp_sum >>> 12;
	assign term = (mul_q + (mul_q[47] ? 48'sd4095 : 48'sd0)) >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			smin_q <= SCALE_MIN_RST;
			smax_q <= SCALE_MAX_RST;
			scale_q <= 32'sd4096;
			out_valid <= 1'b0;
			wait_q <= 1'b0;
			dreq.start <= 1'b0;
		end else begin
			dreq.start <= 1'b0;
			out_valid <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_SCALE_MIN) smin_q <= cfg_data;
				else smax_q <= cfg_data;
			end
			case (st_q)
				S_IDLE: begin
					if (start && int'(row) < ORDER && int'(col) < ORDER) begin
						if (command == CMD_LOAD_LOCAL) loc_q[idx(row, col)] <= value;
						else if (command == CMD_LOAD_TARGET) tgt_q[idx(row, col)] <= value;
					end
					if (start && command == CMD_RUN) begin
						st_q <= S_PIV;
						i_q <= '0;
						scale_q <= 32'sd4096;
					end
				end
				S_PIV: begin
					piv_q <= (loc_q[idx(i_q, i_q)] == 0) ? 17'(ONE_Q12)
						: 17'(loc_q[idx(i_q, i_q)]);
					st_q <= S_PMUL;
					wait_q <= 1'b0;
				end
				S_PMUL: begin
					if (!wait_q) begin
						mul_q <= 48'(mul_a * mul_b);
						wait_q <= 1'b1;
					end else begin
						scale_q <= 32'((48'sd0 + $signed(mul_q[31:0])
							+ ($signed(mul_q[31:0]) < 0 ? 48'sd4095 : 48'sd0)) >>> 12);
						k_q <= '0;
						st_q <= S_NORM;
					end
				end
				S_NORM: begin
					dreq.num <= 48'(loc_q[idx(i_q, k_q)]) <<< 12;
					dreq.den <= piv_q;
					dreq.start <= 1'b1;
					st_q <= S_NDIV;
				end
				S_NDIV: if (drsp.done) begin
					loc_q[idx(i_q, k_q)] <= drsp.quo[15:0];
					if (k_q == lastix) st_q <= S_RECIP;
					else begin k_q <= k_q + 2'd1; st_q <= S_NORM; end
				end
				S_RECIP: begin
					dreq.num <= 48'sd16777216;
					dreq.den <= piv_q;
					dreq.start <= 1'b1;
					st_q <= S_RDIV;
				end
				S_RDIV: if (drsp.done) begin
					loc_q[idx(i_q, i_q)] <= drsp.quo[15:0];
					j_q <= (i_q == 2'd0) ? 2'd1 : 2'd0;
					st_q <= S_ELIM;
				end
				S_ELIM: begin
					u_q <= loc_q[idx(j_q, i_q)];
					k_q <= '0;
					wait_q <= 1'b0;
					st_q <= S_EMUL;
				end
				S_EMUL: begin
					if (k_q == i_q) begin
						dreq.num <= -(48'(u_q) <<< 12);
						dreq.den <= piv_q;
						dreq.start <= 1'b1;
						st_q <= S_EDIV;
					end else if (!wait_q) begin
						mul_q <= 48'(mul_a * mul_b);
						wait_q <= 1'b1;
					end else begin
						loc_q[idx(j_q, k_q)] <= 16'(loc_q[idx(j_q, k_q)] - term[15:0]);
						st_q <= S_EDIV;
					end
				end
				S_EDIV: if (drsp.done || k_q != i_q) begin
					if (k_q == i_q) loc_q[idx(j_q, k_q)] <= drsp.quo[15:0];
					wait_q <= 1'b0;
					if (k_q != lastix) begin
						k_q <= k_q + 2'd1;
						st_q <= S_EMUL;
					end else if (j_q == lastix || (j_q + 2'd1 == i_q && i_q == lastix)) begin
						if (i_q == lastix) st_q <= S_CHK;
						else begin i_q <= i_q + 2'd1; st_q <= S_PIV; end
					end else begin
						j_q <= (j_q + 2'd1 == i_q) ? j_q + 2'd2 : j_q + 2'd1;
						st_q <= S_ELIM;
					end
				end
				S_CHK: begin
					ok_q <= !scale_q[31] && ($unsigned(scale_q) >= 32'(smin_q))
						&& ($unsigned(scale_q) <= 32'(smax_q));
					r_q <= '0; c_q <= '0; k_q <= '0;
					acc_q <= '0; mul_q <= '0; wait_q <= 1'b0;
					st_q <= ((!scale_q[31] && ($unsigned(scale_q) >= 32'(smin_q))
						&& ($unsigned(scale_q) <= 32'(smax_q)))) ? S_COMP : S_EMIT;
				end
				S_COMP: begin
					acc_q <= cmp_sum;
					mul_q <= 48'(mul_a * mul_b);
					if (wait_q) begin
						prod_q[idx(r_q, c_q)] <= (sh > 48'sd32767) ? 16'sh7fff
							: (sh < -48'sd32768) ? 16'sh8000 : sh[15:0];
						acc_q <= '0;
						mul_q <= '0;
						wait_q <= 1'b0;
						k_q <= '0;
						if (c_q == lastix) begin
							c_q <= '0;
							if (r_q == lastix) begin
								st_q <= S_EMIT;
								r_q <= '0;
							end else r_q <= r_q + 2'd1;
						end else c_q <= c_q + 2'd1;
					end else begin
						if (k_q == lastix) begin k_q <= '0; wait_q <= 1'b1; end
						else k_q <= k_q + 2'd1;
					end
				end
				S_EMIT: begin
					out_valid <= 1'b1;
					out_row <= r_q;
					out_col <= c_q;
					out_value <= ok_q ? prod_q[idx(r_q, c_q)] : tgt_q[idx(r_q, c_q)];
					applied <= ok_q;
					last <= (r_q == lastix && c_q == lastix);
					if (ok_q) tgt_q[idx(r_q, c_q)] <= prod_q[idx(r_q, c_q)];
					if (c_q == lastix) begin
						c_q <= '0;
						if (r_q == lastix) st_q <= S_IDLE;
						else r_q <= r_q + 2'd1;
					end else c_q <= c_q + 2'd1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(busy)) else $error("result while idle");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |=> !out_valid) else $error("result after last");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> busy) else $error("divide done while idle");
endmodule
